// ===== rtl/core/tdcg_pkg.sv =====
// Shared types, register indexes and the cosine table builder for the time-of-day gradient block.
`default_nettype none

package tdcg_pkg;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [7:0] column;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_HUE_MIDDAY   = 3'd0;
   localparam csr_index_type CSR_HUE_MIDNIGHT = 3'd1;
   localparam csr_index_type CSR_SAT_MIDDAY   = 3'd2;
   localparam csr_index_type CSR_SAT_MIDNIGHT = 3'd3;
   localparam csr_index_type CSR_VAL_MIDDAY   = 3'd4;
   localparam csr_index_type CSR_VAL_MIDNIGHT = 3'd5;
   localparam csr_index_type CSR_CENTRE_SHIFT = 3'd6;

   // register stages from start to the result strobe
   localparam int unsigned PIPE_LATENCY = 11;

   localparam int unsigned DAY_SECS = 86400;

   localparam longint unsigned Q30_ONE     = 64'd1073741824;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   localparam int unsigned TAYLOR_TERMS = 10;
   // (2n-1)*(2n) for n = 1..10
   localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
      '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306, 64'd380};

   // cos of a Q30 angle, Q30 Taylor series, rounded to Q16 and clamped to 0..65536
   function automatic logic [16:0] cos_q16(input longint unsigned angle);
      longint unsigned a2;
      longint unsigned term;
      longint          sum;
      longint          rnd;
      int              n;
      a2   = (angle * angle) >> 30;
      term = Q30_ONE;
      sum  = longint'(Q30_ONE);
      for (n = 1; n <= int'(TAYLOR_TERMS); n++) begin
         term = ((term * a2) >> 30) / TAYLOR_DIV[n-1];
         if ((n & 1) != 0) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      rnd = (sum + 64'sd8192) >>> 14;
      if (rnd > 64'sd65536) begin
         rnd = 64'sd65536;
      end
      return rnd[16:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/time_of_day_column_gradient_rgb.sv =====
// Top level: pipelined time-of-day / column colour gradient, HSV to RGB.
`default_nettype none

// Takes one word {hour, minute, second, column} per clock and returns one RGB
// word per input, in order. A word is taken on any clock edge with start high
// and busy low; busy is high only while reset is asserted, so the block takes a
// new word every cycle (one word per clock sustained). The result appears on
// rsp_word with rsp_valid high for exactly one cycle, after the word has passed
// the registered stage chain (seconds-of-day, reciprocal multiply for the table
// phase, phase correction, quadrant fold, cosine lookup, three interpolation
// multipliers, truncation and hue wrap, sector split, saturation products,
// the three V*(..) multipliers, and the sector mux into the output register).
// There is no backpressure: the receiver must take every result word. The
// colour registers are written through csr_we/csr_index/csr_wdata, one per
// clock, and should only be changed while no word is in flight; indexes past
// the last register are ignored. The quarter-wave cosine table is a constant
// ROM of COSINE_TABLE_DEPTH+1 entries built at elaboration.
module time_of_day_column_gradient_rgb #(
   parameter int unsigned COLUMN_COUNT       = 53,
   parameter int unsigned COSINE_TABLE_DEPTH = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  tdcg_pkg::req_type       req_word,
   output logic                    rsp_valid,
   output tdcg_pkg::rsp_type       rsp_word,
   input  logic                    csr_we,
   input  tdcg_pkg::csr_index_type csr_index,
   input  logic [tdcg_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tdcg_pkg::*;

   // ---------------------------------------------------------------- sizing
   localparam int unsigned SW   = 17;                          // seconds of day
   localparam int unsigned NUM  = 4 * COSINE_TABLE_DEPTH;      // phase steps per day
   localparam int unsigned PW   = $clog2(NUM);                 // phase width
   localparam int unsigned IW   = $clog2(COSINE_TABLE_DEPTH + 1);
   // phase = floor(sec * NUM / DAY_SECS) by reciprocal, off by at most one
   localparam longint unsigned PREC = (longint'(NUM) << SW) / DAY_SECS;
   localparam int unsigned PCW  = $clog2(PREC + 1);
   localparam int unsigned PPW  = SW + PCW;
   localparam int unsigned XW   = $clog2(longint'(DAY_SECS) * NUM + 1);

   // column proximity and hue shift = shift * prox / MID
   localparam int unsigned MID  = COLUMN_COUNT / 2;
   localparam int unsigned PRW  = $clog2(MID + 1);
   localparam int unsigned AW   = 16 + PRW;                    // |shift| * prox
   localparam longint unsigned RECM = (64'd1 << AW) / MID;
   localparam int unsigned RMW  = $clog2(RECM + 1);
   localparam int unsigned QPW  = AW + RMW;

   localparam logic [SW-1:0] DAY_SECS_S = SW'(DAY_SECS);
   localparam logic [7:0]    COL_LAST   = 8'(COLUMN_COUNT - 1);
   localparam logic [7:0]    COL_MID    = 8'(MID);
   localparam logic [PW-1:0] Q1_START   = PW'(COSINE_TABLE_DEPTH);
   localparam logic [PW-1:0] Q2_START   = PW'(2 * COSINE_TABLE_DEPTH);
   localparam logic [PW-1:0] Q3_START   = PW'(3 * COSINE_TABLE_DEPTH);

   // HSV sectors
   localparam logic [2:0] SEC_RED_YEL = 3'd0;
   localparam logic [2:0] SEC_YEL_GRN = 3'd1;
   localparam logic [2:0] SEC_GRN_CYN = 3'd2;
   localparam logic [2:0] SEC_CYN_BLU = 3'd3;
   localparam logic [2:0] SEC_BLU_MAG = 3'd4;

   // ---------------------------------------------------------- cosine ROM
   logic [16:0] cos_rom [COSINE_TABLE_DEPTH+1];

   for (genvar k = 0; k <= COSINE_TABLE_DEPTH; k++) begin : g_cos
      localparam longint unsigned ANGLE = HALF_PI_Q30 * longint'(k) / COSINE_TABLE_DEPTH;
      assign cos_rom[k] = cos_q16(ANGLE);
   end

   // ------------------------------------------------------------- helpers
   // (day - night) * m, Q16 fraction m in 0..65536
   function automatic logic signed [34:0] lerp_prod(input logic [15:0] day,
                                                   input logic [15:0] night,
                                                   input logic [16:0] m);
      logic signed [16:0] diff;
      logic signed [17:0] mf;
      diff = $signed({1'b0, day}) - $signed({1'b0, night});
      mf   = $signed({1'b0, m});
      return 35'(diff) * 35'(mf);
   endfunction

   // product / 65536 truncated toward zero, low 16 bits
   function automatic logic [15:0] trunc_q16(input logic signed [34:0] prod);
      logic signed [34:0] biased;
      biased = prod + (prod[34] ? 35'sd65535 : 35'sd0);
      return biased[31:16];
   endfunction

   // -------------------------------------------------------- config regs
   logic [15:0] hue_midday_ff,   hue_midday_in;
   logic [15:0] hue_midnight_ff, hue_midnight_in;
   logic [15:0] sat_midday_ff,   sat_midday_in;
   logic [15:0] sat_midnight_ff, sat_midnight_in;
   logic [15:0] val_midday_ff,   val_midday_in;
   logic [15:0] val_midnight_ff, val_midnight_in;
   logic [15:0] centre_shift_ff, centre_shift_in;

   // ------------------------------------------------------ pipeline regs
   logic [PIPE_LATENCY-1:0] vld_ff, vld_in;

   logic [SW-1:0]  st0_sec_ff,   st0_sec_in;
   logic [PRW-1:0] st0_prox_ff,  st0_prox_in;

   logic [SW-1:0]  st1_sec_ff,   st1_sec_in;
   logic [PW-1:0]  st1_p0_ff,    st1_p0_in;
   logic [AW-1:0]  st1_amp_ff,   st1_amp_in;
   logic           st1_neg_ff,   st1_neg_in;

   logic [PW-1:0]  st2_p_ff,     st2_p_in;
   logic [15:0]    st2_q0_ff,    st2_q0_in;
   logic [AW-1:0]  st2_amp_ff,   st2_amp_in;
   logic           st2_neg_ff,   st2_neg_in;

   logic [IW-1:0]  st3_idx_ff,   st3_idx_in;
   logic           st3_cneg_ff,  st3_cneg_in;
   logic [15:0]    st3_shift_ff, st3_shift_in;

   logic [16:0]    st4_m_ff,     st4_m_in;
   logic [15:0]    st4_shift_ff, st4_shift_in;

   logic signed [34:0] st5_ph_ff, st5_ph_in;
   logic signed [34:0] st5_ps_ff, st5_ps_in;
   logic signed [34:0] st5_pv_ff, st5_pv_in;
   logic [15:0]    st5_shift_ff, st5_shift_in;

   logic [15:0]    st6_hue_ff,   st6_hue_in;
   logic [15:0]    st6_sat_ff,   st6_sat_in;
   logic [15:0]    st6_val_ff,   st6_val_in;

   logic [2:0]     st7_sector_ff, st7_sector_in;
   logic [15:0]    st7_frac_ff,   st7_frac_in;
   logic [15:0]    st7_sat_ff,    st7_sat_in;
   logic [23:0]    st7_vq_ff,     st7_vq_in;

   logic [2:0]     st8_sector_ff, st8_sector_in;
   logic [31:0]    st8_fs_ff,     st8_fs_in;
   logic [31:0]    st8_gs_ff,     st8_gs_in;
   logic [16:0]    st8_sc_ff,     st8_sc_in;
   logic [23:0]    st8_vq_ff,     st8_vq_in;

   logic [2:0]     st9_sector_ff, st9_sector_in;
   logic [7:0]     st9_vr_ff,     st9_vr_in;
   logic [7:0]     st9_pp_ff,     st9_pp_in;
   logic [7:0]     st9_qq_ff,     st9_qq_in;
   logic [7:0]     st9_tt_ff,     st9_tt_in;

   rsp_type        rsp_word_ff,   rsp_word_in;

   // ---------------------------------------------------- comb temporaries
   logic [SW-1:0]  sec_sum;
   logic [7:0]     col_clamp;
   logic [7:0]     col_dist;
   logic [PPW-1:0] p_prod;
   logic [15:0]    shift_mag;
   logic [XW-1:0]  sec_scaled;
   logic [XW-1:0]  p_bound;
   logic [QPW-1:0] q_prod;
   logic [PW-1:0]  p_base;
   logic           p_mirror;
   logic [PW-1:0]  p_off;
   logic [IW-1:0]  p_off_n;
   logic [AW-1:0]  q_bound;
   logic [15:0]    q_fix;
   logic [16:0]    cos_val;
   logic [17:0]    m_sum;
   logic [18:0]    hue6;
   logic [40:0]    pp_prod;
   logic [56:0]    qq_prod;
   logic [56:0]    tt_prod;

   assign busy      = reset;
   assign rsp_valid = vld_ff[PIPE_LATENCY-1];
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      // config writes
      hue_midday_in   = hue_midday_ff;
      hue_midnight_in = hue_midnight_ff;
      sat_midday_in   = sat_midday_ff;
      sat_midnight_in = sat_midnight_ff;
      val_midday_in   = val_midday_ff;
      val_midnight_in = val_midnight_ff;
      centre_shift_in = centre_shift_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_HUE_MIDDAY:   hue_midday_in   = csr_wdata;
            CSR_HUE_MIDNIGHT: hue_midnight_in = csr_wdata;
            CSR_SAT_MIDDAY:   sat_midday_in   = csr_wdata;
            CSR_SAT_MIDNIGHT: sat_midnight_in = csr_wdata;
            CSR_VAL_MIDDAY:   val_midday_in   = csr_wdata;
            CSR_VAL_MIDNIGHT: val_midnight_in = csr_wdata;
            CSR_CENTRE_SHIFT: centre_shift_in = csr_wdata;
            default: ;
         endcase
      end

      vld_in = {vld_ff[PIPE_LATENCY-2:0], start && !busy};

      // st0: seconds of day (one wrap covers any 5/6/6-bit input), column proximity
      sec_sum = (SW'(req_word.hour) * SW'(60) + SW'(req_word.minute)) * SW'(60)
              + SW'(req_word.second);
      st0_sec_in = (sec_sum >= DAY_SECS_S) ? sec_sum - DAY_SECS_S : sec_sum;
      col_clamp  = (req_word.column > COL_LAST) ? COL_LAST : req_word.column;
      col_dist   = (col_clamp >= COL_MID) ? col_clamp - COL_MID : COL_MID - col_clamp;
      st0_prox_in = PRW'(COL_MID - col_dist);

      // st1: phase estimate, |shift| * prox
      p_prod     = PPW'(st0_sec_ff) * PPW'(PREC);
      st1_p0_in  = p_prod[SW +: PW];
      st1_sec_in = st0_sec_ff;
      shift_mag  = centre_shift_ff[15] ? (~centre_shift_ff + 16'd1) : centre_shift_ff;
      st1_amp_in = AW'(shift_mag) * AW'(st0_prox_ff);
      st1_neg_in = centre_shift_ff[15];

      // st2: phase correction, quotient estimate for the shift
      sec_scaled = XW'(st1_sec_ff) * XW'(NUM);
      p_bound    = (XW'(st1_p0_ff) + XW'(1)) * XW'(DAY_SECS);
      st2_p_in   = st1_p0_ff + PW'(sec_scaled >= p_bound);
      q_prod     = QPW'(st1_amp_ff) * QPW'(RECM);
      st2_q0_in  = q_prod[AW +: 16];
      st2_amp_in = st1_amp_ff;
      st2_neg_in = st1_neg_ff;

      // st3: quadrant fold into table index; shift quotient correction
      priority if (st2_p_ff >= Q3_START) begin
         p_base = Q3_START; p_mirror = 1'b1; st3_cneg_in = 1'b0;
      end else if (st2_p_ff >= Q2_START) begin
         p_base = Q2_START; p_mirror = 1'b0; st3_cneg_in = 1'b1;
      end else if (st2_p_ff >= Q1_START) begin
         p_base = Q1_START; p_mirror = 1'b1; st3_cneg_in = 1'b1;
      end else begin
         p_base = '0;       p_mirror = 1'b0; st3_cneg_in = 1'b0;
      end
      p_off      = st2_p_ff - p_base;
      p_off_n    = p_off[IW-1:0];
      st3_idx_in = p_mirror ? IW'(COSINE_TABLE_DEPTH) - p_off_n : p_off_n;
      q_bound    = (AW'(st2_q0_ff) + AW'(1)) * AW'(MID);
      q_fix      = st2_q0_ff + 16'(st2_amp_ff >= q_bound);
      st3_shift_in = st2_neg_ff ? (~q_fix + 16'd1) : q_fix;

      // st4: cosine lookup, midday fraction m = (1 - cos) / 2
      cos_val  = cos_rom[st3_idx_ff];
      m_sum    = st3_cneg_ff ? 18'd65536 + 18'(cos_val) : 18'd65536 - 18'(cos_val);
      st4_m_in = m_sum[17:1];
      st4_shift_in = st3_shift_ff;

      // st5: interpolation products
      st5_ph_in = lerp_prod(hue_midday_ff, hue_midnight_ff, st4_m_ff);
      st5_ps_in = lerp_prod(sat_midday_ff, sat_midnight_ff, st4_m_ff);
      st5_pv_in = lerp_prod(val_midday_ff, val_midnight_ff, st4_m_ff);
      st5_shift_in = st4_shift_ff;

      // st6: add back midnight value; hue wraps mod one turn
      st6_hue_in = hue_midnight_ff + trunc_q16(st5_ph_ff) + st5_shift_ff;
      st6_sat_in = sat_midnight_ff + trunc_q16(st5_ps_ff);
      st6_val_in = val_midnight_ff + trunc_q16(st5_pv_ff);

      // st7: sector / fraction, V scaled to 255
      hue6          = 19'(st6_hue_ff) * 19'd6;
      st7_sector_in = hue6[18:16];
      st7_frac_in   = hue6[15:0];
      st7_sat_in    = st6_sat_ff;
      st7_vq_in     = 24'(st6_val_ff) * 24'd255;

      // st8: f*s, (1-f)*s, 1-s
      st8_fs_in     = 32'(st7_frac_ff) * 32'(st7_sat_ff);
      st8_gs_in     = 32'(17'd65536 - 17'(st7_frac_ff)) * 32'(st7_sat_ff);
      st8_sc_in     = 17'd65536 - 17'(st7_sat_ff);
      st8_vq_in     = st7_vq_ff;
      st8_sector_in = st7_sector_ff;

      // st9: p, q, t levels
      pp_prod = 41'(st8_vq_ff) * 41'(st8_sc_ff);
      qq_prod = 57'(st8_vq_ff) * 57'(33'h1_0000_0000 - 33'(st8_fs_ff));
      tt_prod = 57'(st8_vq_ff) * 57'(33'h1_0000_0000 - 33'(st8_gs_ff));
      st9_pp_in     = pp_prod[39:32];
      st9_qq_in     = qq_prod[55:48];
      st9_tt_in     = tt_prod[55:48];
      st9_vr_in     = st8_vq_ff[23:16];
      st9_sector_in = st8_sector_ff;

      // st10: six-sector channel assignment
      unique case (st9_sector_ff)
         SEC_RED_YEL: rsp_word_in = '{red: st9_vr_ff, green: st9_tt_ff, blue: st9_pp_ff};
         SEC_YEL_GRN: rsp_word_in = '{red: st9_qq_ff, green: st9_vr_ff, blue: st9_pp_ff};
         SEC_GRN_CYN: rsp_word_in = '{red: st9_pp_ff, green: st9_vr_ff, blue: st9_tt_ff};
         SEC_CYN_BLU: rsp_word_in = '{red: st9_pp_ff, green: st9_qq_ff, blue: st9_vr_ff};
         SEC_BLU_MAG: rsp_word_in = '{red: st9_tt_ff, green: st9_pp_ff, blue: st9_vr_ff};
         default:     rsp_word_in = '{red: st9_vr_ff, green: st9_pp_ff, blue: st9_qq_ff};
      endcase
   end

   // control and config
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff          <= '0;
         hue_midday_ff   <= 16'd0;
         hue_midnight_ff <= 16'd43690;
         sat_midday_ff   <= 16'd65535;
         sat_midnight_ff <= 16'd65535;
         val_midday_ff   <= 16'd65535;
         val_midnight_ff <= 16'd16384;
         centre_shift_ff <= 16'd0;
      end else begin
         vld_ff          <= vld_in;
         hue_midday_ff   <= hue_midday_in;
         hue_midnight_ff <= hue_midnight_in;
         sat_midday_ff   <= sat_midday_in;
         sat_midnight_ff <= sat_midnight_in;
         val_midday_ff   <= val_midday_in;
         val_midnight_ff <= val_midnight_in;
         centre_shift_ff <= centre_shift_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      st0_sec_ff    <= st0_sec_in;
      st0_prox_ff   <= st0_prox_in;
      st1_sec_ff    <= st1_sec_in;
      st1_p0_ff     <= st1_p0_in;
      st1_amp_ff    <= st1_amp_in;
      st1_neg_ff    <= st1_neg_in;
      st2_p_ff      <= st2_p_in;
      st2_q0_ff     <= st2_q0_in;
      st2_amp_ff    <= st2_amp_in;
      st2_neg_ff    <= st2_neg_in;
      st3_idx_ff    <= st3_idx_in;
      st3_cneg_ff   <= st3_cneg_in;
      st3_shift_ff  <= st3_shift_in;
      st4_m_ff      <= st4_m_in;
      st4_shift_ff  <= st4_shift_in;
      st5_ph_ff     <= st5_ph_in;
      st5_ps_ff     <= st5_ps_in;
      st5_pv_ff     <= st5_pv_in;
      st5_shift_ff  <= st5_shift_in;
      st6_hue_ff    <= st6_hue_in;
      st6_sat_ff    <= st6_sat_in;
      st6_val_ff    <= st6_val_in;
      st7_sector_ff <= st7_sector_in;
      st7_frac_ff   <= st7_frac_in;
      st7_sat_ff    <= st7_sat_in;
      st7_vq_ff     <= st7_vq_in;
      st8_sector_ff <= st8_sector_in;
      st8_fs_ff     <= st8_fs_in;
      st8_gs_ff     <= st8_gs_in;
      st8_sc_ff     <= st8_sc_in;
      st8_vq_ff     <= st8_vq_in;
      st9_sector_ff <= st9_sector_in;
      st9_vr_ff     <= st9_vr_in;
      st9_pp_ff     <= st9_pp_in;
      st9_qq_ff     <= st9_qq_in;
      st9_tt_ff     <= st9_tt_in;
      rsp_word_ff   <= rsp_word_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/tdcg_checker.sv =====
// Port-level checks for the time-of-day gradient block, bound to the top level.
`default_nettype none

module tdcg_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input tdcg_pkg::req_type req_word,
   input logic              rsp_valid,
   input tdcg_pkg::rsp_type rsp_word,
   input logic              csr_we
);
   import tdcg_pkg::*;

   localparam int unsigned     CW     = $clog2(PIPE_LATENCY + 3);
   localparam logic [CW-1:0]   WARM   = CW'(PIPE_LATENCY);
   localparam logic [CW-1:0]   WARM1  = CW'(PIPE_LATENCY + 1);
   localparam logic [CW-1:0]   QUIET  = CW'(PIPE_LATENCY + 2);

   logic [CW-1:0] warm_ff, warm_in;
   logic [CW-1:0] quiet_ff, quiet_in;
   logic          pristine_ff, pristine_in;
   logic          accept;
   logic          at_midnight;

   assign accept      = start && !busy;
   assign at_midnight = (req_word.hour == 5'd0) && (req_word.minute == 6'd0)
                     && (req_word.second == 6'd0);

   always_comb begin
      warm_in     = (warm_ff == QUIET) ? warm_ff : warm_ff + CW'(1);
      quiet_in    = csr_we ? '0 : ((quiet_ff == QUIET) ? quiet_ff : quiet_ff + CW'(1));
      pristine_in = pristine_ff && !csr_we;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         warm_ff     <= '0;
         quiet_ff    <= '0;
         pristine_ff <= 1'b1;
      end else begin
         warm_ff     <= warm_in;
         quiet_ff    <= quiet_in;
         pristine_ff <= pristine_in;
      end
   end

   // every accepted word gives exactly one strobe, fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (warm_ff >= WARM) |-> (rsp_valid == $past(accept, PIPE_LATENCY)))
      else $error("result strobe does not track accepted words");

   // pipeline flushed by reset
   a_reset_flush: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");

   // same word twice in a row under stable config gives the same colour twice
   a_repeat: assert property (@(posedge clock) disable iff (reset)
      ((warm_ff >= WARM1) && (quiet_ff == QUIET) && $past(accept, PIPE_LATENCY)
       && $past(accept, PIPE_LATENCY + 1)
       && ($past(req_word, PIPE_LATENCY) == $past(req_word, PIPE_LATENCY + 1)))
      |-> (rsp_word == $past(rsp_word)))
      else $error("identical words gave different colours");

   // reset colours at midnight: deep blue at quarter value
   a_midnight: assert property (@(posedge clock) disable iff (reset)
      ((warm_ff >= WARM) && pristine_ff && $past(accept && at_midnight, PIPE_LATENCY))
      |-> ((rsp_word.red == 8'd0) && (rsp_word.green == 8'd0) && (rsp_word.blue == 8'd63)))
      else $error("midnight colour wrong with reset registers");

endmodule

bind time_of_day_column_gradient_rgb tdcg_checker u_tdcg_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_word  (rsp_word),
   .csr_we    (csr_we)
);

`default_nettype wire

// ===== verif/time_of_day_column_gradient_rgb_test.sv =====
// Self-checking test of the time-of-day column gradient block: directed and random words.
module time_of_day_column_gradient_rgb_test;
   import tdcg_pkg::*;

   localparam int unsigned COLUMNS   = 53;
   localparam int unsigned COS_DEPTH = 256;
   localparam int unsigned MID_COL   = COLUMNS / 2;
   localparam longint unsigned Q30   = 64'd1 << 30;

   // index past the last colour register, writes to it must be dropped
   localparam csr_index_type CSR_UNUSED = 3'd7;

   logic          clock;
   logic          reset;
   logic          start;
   logic          busy;
   req_type       req_word;
   logic          rsp_valid;
   rsp_type       rsp_word;
   logic          csr_we;
   csr_index_type csr_index;
   logic [15:0]   csr_wdata;

   time_of_day_column_gradient_rgb #(
      .COLUMN_COUNT      (COLUMNS),
      .COSINE_TABLE_DEPTH(COS_DEPTH)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_word (rsp_word),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // words waiting to be driven, and colours still owed by the block
   req_type     time_words [$];
   rsp_type     rgb_due [$];
   int unsigned error_count = 0;

   // shadow of the colour registers and the quarter-wave cosine table (Q16)
   bit [15:0]   colour_reg [7];
   int unsigned cos_tab [COS_DEPTH+1];

   // set by the monitor at the rising edge, read by the driver at the falling edge
   bit          req_taken = 1'b0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // cos(pi/2 * k/depth): Q30 Taylor series, truncated products, then Q16
   function automatic int unsigned quarter_cos(int unsigned k);
      longint unsigned ang;
      longint unsigned ang2;
      longint unsigned term;
      longint          acc;
      int unsigned     n;
      ang  = HALF_PI_Q30 * longint'(k) / longint'(COS_DEPTH);
      ang2 = (ang * ang) >> 30;
      term = Q30;
      acc  = longint'(Q30);
      for (n = 1; n <= 10; n++) begin
         term = ((term * ang2) >> 30) / 64'((2 * n - 1) * (2 * n));
         if (n % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      acc = (acc + 8192) / 16384;
      if (acc > 65536) begin
         acc = 65536;
      end
      return int'(acc);
   endfunction

   // linear blend from the midnight value (m = 0) to the midday value (m = 65536)
   function automatic longint blend(bit [15:0] night, bit [15:0] day, longint m);
      longint d;
      d = longint'(day) - longint'(night);
      return longint'(night) + (d * m) / 65536;
   endfunction

   function automatic rsp_type column_colour(req_type w);
      longint unsigned secs, phase, quad, ofs;
      longint          cosv, mfrac, hue, sat, val, shift, col_off, prox;
      longint unsigned h6, f, sector, sa, vq, vr, pp, qq, tt;
      longint unsigned red, green, blue;
      int unsigned     col;
      rsp_type         o;
      // seconds of day; out-of-range fields still count, then wrap
      secs  = (64'(w.hour) * 60 + 64'(w.minute)) * 60 + 64'(w.second);
      secs  = secs % DAY_SECS;
      phase = secs * 4 * COS_DEPTH / DAY_SECS;
      quad  = phase / COS_DEPTH;
      ofs   = phase % COS_DEPTH;
      case (quad[1:0])
         2'd0: cosv =  longint'(cos_tab[ofs]);
         2'd1: cosv = -longint'(cos_tab[COS_DEPTH - ofs]);
         2'd2: cosv = -longint'(cos_tab[ofs]);
         default: cosv = longint'(cos_tab[COS_DEPTH - ofs]);
      endcase
      mfrac = (65536 - cosv) / 2;

      hue = blend(colour_reg[CSR_HUE_MIDNIGHT], colour_reg[CSR_HUE_MIDDAY], mfrac);
      sat = blend(colour_reg[CSR_SAT_MIDNIGHT], colour_reg[CSR_SAT_MIDDAY], mfrac);
      val = blend(colour_reg[CSR_VAL_MIDNIGHT], colour_reg[CSR_VAL_MIDDAY], mfrac);

      // centre proximity; columns past the end act as the last one
      col = w.column;
      if (col > COLUMNS - 1) begin
         col = COLUMNS - 1;
      end
      col_off = longint'(col) - longint'(MID_COL);
      if (col_off < 0) begin
         col_off = -col_off;
      end
      prox = longint'(MID_COL) - col_off;
      if (prox < 0) begin
         prox = 0;
      end
      shift = longint'($signed(colour_reg[CSR_CENTRE_SHIFT]));
      hue   = hue + (shift * prox) / longint'(MID_COL);
      hue   = hue & 64'hFFFF;   // hue wraps around the circle

      h6     = 64'(hue) * 6;
      sector = h6 >> 16;
      f      = h6 & 64'hFFFF;
      sa     = 64'(sat);
      vq     = 64'(val) * 255;
      vr     = vq >> 16;
      pp     = (vq * (65536 - sa)) >> 32;
      qq     = (vq * ((64'd1 << 32) - f * sa)) >> 48;
      tt     = (vq * ((64'd1 << 32) - (65536 - f) * sa)) >> 48;

      case (sector)
         0: begin red = vr; green = tt; blue = pp; end
         1: begin red = qq; green = vr; blue = pp; end
         2: begin red = pp; green = vr; blue = tt; end
         3: begin red = pp; green = qq; blue = vr; end
         4: begin red = tt; green = pp; blue = vr; end
         default: begin red = vr; green = pp; blue = qq; end
      endcase
      o.red   = red[7:0];
      o.green = green[7:0];
      o.blue  = blue[7:0];
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Monitor: everything sampled at the rising edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_taken = 1'b0;
         colour_reg[CSR_HUE_MIDDAY]   = 16'd0;
         colour_reg[CSR_HUE_MIDNIGHT] = 16'd43690;
         colour_reg[CSR_SAT_MIDDAY]   = 16'd65535;
         colour_reg[CSR_SAT_MIDNIGHT] = 16'd65535;
         colour_reg[CSR_VAL_MIDDAY]   = 16'd65535;
         colour_reg[CSR_VAL_MIDNIGHT] = 16'd16384;
         colour_reg[CSR_CENTRE_SHIFT] = 16'd0;
      end else begin
         // result strobe: compare with the oldest owed colour
         if (rsp_valid) begin
            if (rgb_due.size() == 0) begin
               $error("unexpected result word %h", rsp_word);
               error_count++;
            end else begin
               want = rgb_due.pop_front();
               if (rsp_word.red !== want.red) begin
                  $error("red: expected %0d, got %0d", want.red, rsp_word.red);
                  error_count++;
               end
               if (rsp_word.green !== want.green) begin
                  $error("green: expected %0d, got %0d", want.green, rsp_word.green);
                  error_count++;
               end
               if (rsp_word.blue !== want.blue) begin
                  $error("blue: expected %0d, got %0d", want.blue, rsp_word.blue);
                  error_count++;
               end
            end
         end
         // accepted word is predicted with the registers as they stand now
         req_taken = start && !busy;
         if (req_taken) begin
            rgb_due.push_back(column_colour(req_word));
         end
         // writes past the last register are dropped
         if (csr_we && csr_index <= CSR_CENTRE_SHIFT) begin
            colour_reg[csr_index] = csr_wdata;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Driver: falling edge, random gaps with occasional gapless bursts
   // ---------------------------------------------------------------------
   int unsigned gap_left   = 0;
   int unsigned burst_left = 0;

   always @(negedge clock) begin
      int unsigned roll;
      if (reset) begin
         start    <= 1'b0;
         req_word <= '0;
      end else if (start && !req_taken) begin
         // hold the word until it is taken
      end else if (gap_left > 0) begin
         start <= 1'b0;
         gap_left--;
      end else if (time_words.size() != 0) begin
         start    <= 1'b1;
         req_word <= time_words.pop_front();
         if (burst_left > 0) begin
            burst_left--;
            gap_left = 0;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
               burst_left = $urandom_range(20, 60);
               gap_left   = 0;
            end else if (roll < 50) begin
               gap_left = 0;
            end else if (roll < 85) begin
               gap_left = $urandom_range(1, 3);
            end else if (roll < 97) begin
               gap_left = $urandom_range(4, 12);
            end else begin
               gap_left = $urandom_range(20, 60);
            end
         end
      end else begin
         start <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic queue_time(int unsigned h, int unsigned m, int unsigned s, int unsigned c);
      req_type w;
      w.hour   = h[4:0];
      w.minute = m[5:0];
      w.second = s[5:0];
      w.column = c[7:0];
      time_words.push_back(w);
   endtask

   // mostly legal times and columns, now and then anything the fields can hold
   task automatic queue_random(int unsigned count);
      int unsigned i;
      for (i = 0; i < count; i++) begin
         queue_time(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 23),
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 59),
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 59),
                    ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                : $urandom_range(0, COLUMNS - 1));
      end
   endtask

   // registers change only with nothing in flight; checked at the rising edge,
   // where start and the word queue are settled
   task automatic wait_idle();
      while (time_words.size() != 0 || start || rgb_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_reg(csr_index_type idx, bit [15:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   task automatic end_writes();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // extremes often, the rest uniform
   function automatic bit [15:0] reg_value();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         3: return 16'h7FFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   initial begin
      int unsigned k;
      int unsigned phase_no;

      for (k = 0; k <= COS_DEPTH; k++) begin
         cos_tab[k] = quarter_cos(k);
      end

      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_index = CSR_HUE_MIDDAY;
      csr_wdata = 16'd0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // reset colours: midnight, midday, quarter points, end of day,
      // out-of-range time fields, column edges, centre and past the end
      queue_time(0, 0, 0, 0);
      queue_time(12, 0, 0, MID_COL);
      queue_time(6, 0, 0, COLUMNS - 1);
      queue_time(18, 0, 0, COLUMNS);
      queue_time(23, 59, 59, 255);
      queue_time(31, 63, 63, 0);
      queue_time(24, 0, 0, MID_COL);
      queue_time(3, 15, 30, 10);
      queue_time(9, 45, 15, 40);
      queue_time(15, 30, 45, 128);
      queue_time(21, 0, 1, 1);
      wait_idle();

      // full hue sweep over the day, full sat/value, largest positive shift:
      // hue overflows at the centre
      write_reg(CSR_HUE_MIDDAY, 16'hFFFF);
      write_reg(CSR_HUE_MIDNIGHT, 16'h0000);
      write_reg(CSR_SAT_MIDDAY, 16'hFFFF);
      write_reg(CSR_SAT_MIDNIGHT, 16'hFFFF);
      write_reg(CSR_VAL_MIDDAY, 16'hFFFF);
      write_reg(CSR_VAL_MIDNIGHT, 16'hFFFF);
      write_reg(CSR_CENTRE_SHIFT, 16'h7FFF);
      end_writes();
      queue_time(2, 0, 0, MID_COL);
      queue_time(6, 0, 0, MID_COL);
      queue_time(10, 0, 0, MID_COL);
      queue_time(12, 0, 0, MID_COL);
      queue_time(14, 0, 0, 20);
      queue_time(20, 0, 0, 30);
      wait_idle();

      // all zero but the midnight value, most negative shift: hue wraps below zero; dead index write
      write_reg(CSR_HUE_MIDDAY, 16'h0000);
      write_reg(CSR_SAT_MIDDAY, 16'h0000);
      write_reg(CSR_SAT_MIDNIGHT, 16'h0000);
      write_reg(CSR_VAL_MIDDAY, 16'h0000);
      write_reg(CSR_CENTRE_SHIFT, 16'h8000);
      write_reg(CSR_UNUSED, 16'hFFFF);
      end_writes();
      queue_time(0, 0, 0, MID_COL);
      queue_time(12, 0, 0, MID_COL);
      queue_time(18, 30, 0, 25);
      queue_time(7, 7, 7, 200);
      wait_idle();

      // random colour settings, one batch of words per setting
      for (phase_no = 0; phase_no < 8; phase_no++) begin
         write_reg(CSR_HUE_MIDDAY, reg_value());
         write_reg(CSR_HUE_MIDNIGHT, reg_value());
         write_reg(CSR_SAT_MIDDAY, reg_value());
         write_reg(CSR_SAT_MIDNIGHT, reg_value());
         write_reg(CSR_VAL_MIDDAY, reg_value());
         write_reg(CSR_VAL_MIDNIGHT, reg_value());
         write_reg(CSR_CENTRE_SHIFT, reg_value());
         end_writes();
         queue_random(60);
         wait_idle();
      end

      // catch any stray strobe after the last colour
      repeat (PIPE_LATENCY + 5) @(negedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // hard stop, far beyond the slowest legal run
   initial begin
      #1600000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/tdcg_pkg.sv
rtl/core/time_of_day_column_gradient_rgb.sv
rtl/core/tdcg_checker.sv
verif/time_of_day_column_gradient_rgb_test.sv
